FILE: hdl/wsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg: shared types and constants of the waypoint steering controller
// Widths, reset values, status and register codes, CORDIC angle table.
// ----------------------------------------------------------------------------
package wsc_pkg;

  // Waypoint table
  localparam int WP_DEPTH = 64;
  localparam int WP_AW    = $clog2(WP_DEPTH);
  localparam int WP_W     = 32;

  // CORDIC
  localparam int CORDIC_ITERS    = 14;
  localparam int IT_W            = $clog2(CORDIC_ITERS);
  localparam int CORDIC_PRESHIFT = 6;
  localparam int CW              = 26;   // x / y datapath
  localparam int ZW              = 18;   // angle accumulator, degrees Q8

  // Field widths
  localparam int TGT_W    = 6;
  localparam int LEN_W    = 7;
  localparam int RAD_W    = 12;
  localparam int SPD_W    = 7;
  localparam int POS_W    = 16;
  localparam int HDG_W    = 10;
  localparam int WHEEL_W  = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int DIFF_W   = POS_W + 1;

  // Shared multiplier and derived arithmetic
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SQ_W     = 2 * DIFF_W - 1;   // one squared difference
  localparam int D2_W     = SQ_W + 1;
  localparam int R2_W     = 2 * RAD_W;
  localparam int NUM_W    = 20;               // wheel numerators, degrees Q8
  localparam int WHEEL_SH = 8;                // 768 = 3 << 8
  localparam int RECIP3   = 43691;            // ceil(2^17 / 3)
  localparam int RECIP_SH = 17;
  localparam int Q_W      = 10;

  localparam logic signed [ZW-1:0]    HALF_TURN_Z   = ZW'(180 * 256);
  localparam logic signed [NUM_W-1:0] HALF_TURN_Q8  = NUM_W'(180 * 256);
  localparam logic signed [NUM_W-1:0] FULL_TURN_Q8  = NUM_W'(360 * 256);

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ROUTE_LENGTH   = 2'd0,
    CFG_ARRIVAL_RADIUS = 2'd1,
    CFG_BASE_SPEED     = 2'd2,
    CFG_SPEED_LIMIT    = 2'd3
  } cfg_reg_e;

  localparam logic [LEN_W-1:0] ROUTE_LENGTH_RST   = '0;
  localparam logic [RAD_W-1:0] ARRIVAL_RADIUS_RST = RAD_W'(200);
  localparam logic [SPD_W-1:0] BASE_SPEED_RST     = SPD_W'(20);
  localparam logic [SPD_W-1:0] SPEED_LIMIT_RST    = SPD_W'(20);

  // Item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POSE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STARTED  = 3'd0,
    ST_ADVANCED = 3'd1,
    ST_ARRIVED  = 3'd2,
    ST_STEERING = 3'd3,
    ST_NO_ROUTE = 3'd4
  } status_e;

  // Request and response of the CORDIC unit
  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
  } cor_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [ZW-1:0] z;
  } cor_rsp_t;

  // round(atan(2^-i) * 180/pi * 256)
  function automatic logic signed [ZW-1:0] atan_q8(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:    a = ZW'(11520);
      5'd1:    a = ZW'(6801);
      5'd2:    a = ZW'(3593);
      5'd3:    a = ZW'(1824);
      5'd4:    a = ZW'(916);
      5'd5:    a = ZW'(458);
      5'd6:    a = ZW'(229);
      5'd7:    a = ZW'(115);
      5'd8:    a = ZW'(57);
      5'd9:    a = ZW'(29);
      5'd10:   a = ZW'(14);
      5'd11:   a = ZW'(7);
      5'd12:   a = ZW'(4);
      5'd13:   a = ZW'(2);
      5'd14:   a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/wsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_if: channel interfaces of the waypoint steering controller
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface wsc_item_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [5:0]        wp_slot;
  logic signed [15:0] wp_pos_x;
  logic signed [15:0] wp_pos_y;
  logic signed [15:0] robot_x;
  logic signed [15:0] robot_y;
  logic signed [9:0] heading_deg;

  modport source (output valid, operation, wp_slot, wp_pos_x, wp_pos_y,
                  robot_x, robot_y, heading_deg, input ready);
  modport sink (input valid, operation, wp_slot, wp_pos_x, wp_pos_y,
                robot_x, robot_y, heading_deg, output ready);
endinterface

interface wsc_result_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [7:0] left_speed;
  logic signed [7:0] right_speed;
  logic [5:0]        target_index;

  modport source (output valid, status, left_speed, right_speed, target_index,
                  input ready);
  modport sink (input valid, status, left_speed, right_speed, target_index,
                output ready);
endinterface

interface wsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [11:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

FILE: hdl/waypoint_steering_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_steering_controller: waypoint table and differential-drive steering
// Loads waypoints, checks arrival and steers both wheels toward the target.
// ----------------------------------------------------------------------------
// A load item writes one waypoint into the table in its accept cycle and gives
// no result; the block is ready again the next cycle. A pose tick gives one
// result item. With no route loaded, or on the first tick after reset, the
// block goes straight to the emit step. Every later tick reads the target
// from the table, forms the squared distance and the squared arrival radius on
// one shared 18x18 multiplier, and on arrival goes to the emit step. A steering
// tick then runs the CORDIC unit, one rotation per cycle, and returns to the
// same multiplier for the two wheel scalings. The block takes one pose tick at
// a time; a finished result sits in an output register, so the next item is
// accepted while it waits. Write the configuration registers only while the
// block is idle. Waypoint slots that were never loaded read as undefined.
// ----------------------------------------------------------------------------
module waypoint_steering_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsc_item_if.sink     item_i,
  wsc_result_if.source result_o,
  wsc_cfg_if.sink      cfg_i
);
  import wsc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_FETCH = 10'b00_0000_0010,
    S_SQX   = 10'b00_0000_0100,
    S_SQY   = 10'b00_0000_1000,
    S_CMP   = 10'b00_0001_0000,
    S_ROT   = 10'b00_0010_0000,
    S_WL    = 10'b00_0100_0000,
    S_WR    = 10'b00_1000_0000,
    S_WF    = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_e;

  // Magnitude of a wheel numerator.
  function automatic logic [NUM_W-1:0] mag_of(input logic signed [NUM_W-1:0] v);
    return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
  endfunction

  // Take the quotient out of the reciprocal product, clamp, restore the sign.
  function automatic logic signed [WHEEL_W-1:0] wheel_finish(
    input logic signed [PROD_W-1:0] p,
    input logic                     neg,
    input logic [SPD_W-1:0]         lim
  );
    logic [Q_W-1:0]   q;
    logic [SPD_W-1:0] qc;
    q  = p[RECIP_SH+Q_W-1:RECIP_SH];
    qc = (q > Q_W'(lim)) ? lim : q[SPD_W-1:0];
    return neg ? -$signed(WHEEL_W'(qc)) : $signed(WHEEL_W'(qc));
  endfunction

  // Control state
  state_e             state_q, state_d;
  logic               started_q, started_d;
  logic [TGT_W-1:0]   target_q, target_d;
  logic [LEN_W-1:0]   route_len_q, route_len_d;
  logic [RAD_W-1:0]   radius_q, radius_d;
  logic [SPD_W-1:0]   base_q, base_d;
  logic [SPD_W-1:0]   limit_q, limit_d;
  logic               out_valid_q, out_valid_d;

  // Result and working registers
  status_e                   out_status_q, out_status_d;
  logic signed [WHEEL_W-1:0] out_left_q, out_left_d, out_right_q, out_right_d;
  logic [TGT_W-1:0]          out_target_q, out_target_d;
  status_e                   st_q, st_d;
  logic signed [WHEEL_W-1:0] left_q, left_d, right_q, right_d;
  logic                      neg_q, neg_d;
  logic signed [POS_W-1:0]   robot_x_q, robot_x_d, robot_y_q, robot_y_d;
  logic signed [HDG_W-1:0]   heading_q, heading_d;
  logic signed [DIFF_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [R2_W-1:0]           r2_q, r2_d;
  logic [SQ_W-1:0]           acc_q, acc_d;
  logic signed [NUM_W-1:0]   e_q, e_d;
  logic signed [PROD_W-1:0]  prod_q;

  // Shared multiplier operands
  logic signed [MUL_W-1:0] mul_a, mul_b;

  logic                    item_acc;
  logic [LEN_W-1:0]        len;
  logic                    ram_we, ram_re;
  logic [WP_W-1:0]         ram_rdata;
  logic signed [POS_W-1:0] wp_x, wp_y;
  logic [D2_W-1:0]         d2;
  logic signed [NUM_W-1:0] base_scaled, num_l, num_r, e_raw;
  cor_req_t                cor_req;
  cor_rsp_t                cor_rsp;

  // Clamp the route to the table depth.
  assign len = (int'(route_len_q) > WP_DEPTH) ? LEN_W'(WP_DEPTH) : route_len_q;

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Waypoint store: x in the low half, y in the high half.
  assign ram_we = item_acc && (item_i.operation == OP_LOAD) &&
                  (int'(item_i.wp_slot) < WP_DEPTH);
  assign ram_re = item_acc && (item_i.operation == OP_POSE);

  wsc_ram #(
    .WIDTH (WP_W),
    .DEPTH (WP_DEPTH)
  ) u_wp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (WP_AW'(item_i.wp_slot)),
    .wdata_i ({item_i.wp_pos_y, item_i.wp_pos_x}),
    .re_i    (ram_re),
    .raddr_i (WP_AW'(target_q)),
    .rdata_o (ram_rdata)
  );

  assign wp_x = $signed(ram_rdata[POS_W-1:0]);
  assign wp_y = $signed(ram_rdata[2*POS_W-1:POS_W]);

  // Squared distance: dx^2 held in acc, dy^2 on the multiplier output.
  assign d2 = {1'b0, acc_q} + {1'b0, prod_q[SQ_W-1:0]};

  // Wheel numerators: base * 768 -/+ heading error.
  assign base_scaled = $signed((NUM_W'(base_q) << 9) + (NUM_W'(base_q) << 8));
  assign num_l       = base_scaled - e_q;
  assign num_r       = base_scaled + e_q;

  // Heading error from the CORDIC angle.
  assign e_raw = (NUM_W'(heading_q) <<< 8) + NUM_W'(cor_rsp.z);

  assign cor_req.start = (state_q == S_CMP) && !(d2 < D2_W'(r2_q));
  assign cor_req.x     = dx_q;
  assign cor_req.y     = dy_q;

  wsc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  // Pick the multiplier operands for each step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_FETCH: begin
        mul_a = $signed(MUL_W'(radius_q));
        mul_b = $signed(MUL_W'(radius_q));
      end
      S_SQX: begin
        mul_a = MUL_W'(dx_q);
        mul_b = MUL_W'(dx_q);
      end
      S_SQY: begin
        mul_a = MUL_W'(dy_q);
        mul_b = MUL_W'(dy_q);
      end
      S_WL: begin
        mul_a = $signed(MUL_W'(mag_of(num_l) >> WHEEL_SH));
        mul_b = $signed(MUL_W'(RECIP3));
      end
      S_WR: begin
        mul_a = $signed(MUL_W'(mag_of(num_r) >> WHEEL_SH));
        mul_b = $signed(MUL_W'(RECIP3));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    started_d    = started_q;
    target_d     = target_q;
    route_len_d  = route_len_q;
    radius_d     = radius_q;
    base_d       = base_q;
    limit_d      = limit_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_left_d   = out_left_q;
    out_right_d  = out_right_q;
    out_target_d = out_target_q;
    st_d         = st_q;
    left_d       = left_q;
    right_d      = right_q;
    neg_d        = neg_q;
    robot_x_d    = robot_x_q;
    robot_y_d    = robot_y_q;
    heading_d    = heading_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    r2_d         = r2_q;
    acc_d        = acc_q;
    e_d          = e_q;

    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.addr))
        CFG_ROUTE_LENGTH:   route_len_d = cfg_i.wdata[LEN_W-1:0];
        CFG_ARRIVAL_RADIUS: radius_d    = cfg_i.wdata[RAD_W-1:0];
        CFG_BASE_SPEED:     base_d      = cfg_i.wdata[SPD_W-1:0];
        CFG_SPEED_LIMIT:    limit_d     = cfg_i.wdata[SPD_W-1:0];
      endcase
    end

    // Drop the held result once it is taken.
    if (result_o.valid && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_acc && item_i.operation == OP_POSE) begin
          robot_x_d = item_i.robot_x;
          robot_y_d = item_i.robot_y;
          heading_d = item_i.heading_deg;
          left_d    = '0;
          right_d   = '0;
          if (len == '0) begin
            st_d    = ST_NO_ROUTE;
            state_d = S_EMIT;
          end else if (!started_q) begin
            started_d = 1'b1;
            target_d  = '0;
            st_d      = ST_STARTED;
            state_d   = S_EMIT;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        dx_d    = DIFF_W'(robot_x_q) - DIFF_W'(wp_x);
        dy_d    = DIFF_W'(robot_y_q) - DIFF_W'(wp_y);
        state_d = S_SQX;
      end
      S_SQX: begin
        r2_d    = prod_q[R2_W-1:0];
        state_d = S_SQY;
      end
      S_SQY: begin
        acc_d   = prod_q[SQ_W-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        if (d2 < D2_W'(r2_q)) begin
          // Arrived: advance, or stop at the end of the route.
          if (LEN_W'(target_q) + LEN_W'(1) < len) begin
            target_d = target_q + 1'b1;
            st_d     = ST_ADVANCED;
          end else begin
            st_d = ST_ARRIVED;
          end
          state_d = S_EMIT;
        end else begin
          st_d    = ST_STEERING;
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        if (cor_rsp.done) begin
          e_d     = (e_raw > HALF_TURN_Q8) ? e_raw - FULL_TURN_Q8 : e_raw;
          state_d = S_WL;
        end
      end
      S_WL: begin
        neg_d   = num_l[NUM_W-1];
        state_d = S_WR;
      end
      S_WR: begin
        left_d  = wheel_finish(prod_q, neg_q, limit_q);
        neg_d   = num_r[NUM_W-1];
        state_d = S_WF;
      end
      S_WF: begin
        right_d = wheel_finish(prod_q, neg_q, limit_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register is free.
        if (!out_valid_q || result_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_left_d   = left_q;
          out_right_d  = right_q;
          out_target_d = target_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      target_q    <= '0;
      route_len_q <= ROUTE_LENGTH_RST;
      radius_q    <= ARRIVAL_RADIUS_RST;
      base_q      <= BASE_SPEED_RST;
      limit_q     <= SPEED_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      target_q    <= target_d;
      route_len_q <= route_len_d;
      radius_q    <= radius_d;
      base_q      <= base_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_left_q   <= out_left_d;
    out_right_q  <= out_right_d;
    out_target_q <= out_target_d;
    st_q         <= st_d;
    left_q       <= left_d;
    right_q      <= right_d;
    neg_q        <= neg_d;
    robot_x_q    <= robot_x_d;
    robot_y_q    <= robot_y_d;
    heading_q    <= heading_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    r2_q         <= r2_d;
    acc_q        <= acc_d;
    e_q          <= e_d;
    prod_q       <= mul_a * mul_b;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_status_q;
  assign result_o.left_speed   = out_left_q;
  assign result_o.right_speed  = out_right_q;
  assign result_o.target_index = out_target_q;

  // Only a steering result carries wheel speeds.
  a_speeds_zero_unless_steering: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.status != ST_STEERING) |->
      (result_o.left_speed == '0 && result_o.right_speed == '0))
  else $error("wheel speeds nonzero outside steering");

  // Wheel commands stay inside the configured clamp.
  a_speed_within_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      ($signed(result_o.left_speed) <= $signed(WHEEL_W'(limit_q)) &&
       $signed(result_o.left_speed) >= -$signed(WHEEL_W'(limit_q)) &&
       $signed(result_o.right_speed) <= $signed(WHEEL_W'(limit_q)) &&
       $signed(result_o.right_speed) >= -$signed(WHEEL_W'(limit_q))))
  else $error("wheel speed beyond limit");

  // Once started, the route stays started until reset.
  a_started_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
  else $error("started flag cleared");

  // The CORDIC unit only finishes while the sequencer waits for it.
  a_cordic_done_in_rot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cor_rsp.done |-> (state_q == S_ROT))
  else $error("CORDIC finished outside rotation step");

endmodule

FILE: hdl/wsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/wsc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_cordic: iterative vectoring CORDIC for atan2
// One micro-rotation per cycle on a shared add/shift datapath, angle in
// degrees Q8.
// ----------------------------------------------------------------------------
module wsc_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsc_pkg::cor_req_t   req_i,
  output wsc_pkg::cor_rsp_t   rsp_o
);
  import wsc_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_DONE = 3'b100
  } cstate_e;

  cstate_e              state_q, state_d;
  logic [IT_W-1:0]      iter_q, iter_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;

  logic signed [CW-1:0] x_in, y_in, xs, ys;

  assign x_in = CW'(req_i.x) <<< CORDIC_PRESHIFT;
  assign y_in = CW'(req_i.y) <<< CORDIC_PRESHIFT;
  assign xs   = x_q >>> iter_q;
  assign ys   = y_q >>> iter_q;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          iter_d = '0;
          if (req_i.x == '0 && req_i.y == '0) begin
            // zero vector: angle is zero, skip the rotations
            z_d     = '0;
            state_d = C_DONE;
          end else if (req_i.x < 0) begin
            // fold into the right half-plane
            x_d     = -x_in;
            y_d     = -y_in;
            z_d     = (req_i.y >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
            state_d = C_RUN;
          end else begin
            x_d     = x_in;
            y_d     = y_in;
            z_d     = '0;
            state_d = C_RUN;
          end
        end
      end
      C_RUN: begin
        if (y_q >= 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_q8(5'(iter_q));
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_q8(5'(iter_q));
        end
        if (iter_q == IT_W'(CORDIC_ITERS - 1)) begin
          state_d = C_DONE;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.done = (state_q == C_DONE);
  assign rsp_o.z    = z_q;

endmodule
